[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the slab allocator.
// Needs signals named clock and reset in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define AST_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define AST_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define AST_IMPLY(name, ante, cons)
`define AST_NEXT(name, ante, cons)
`endif
`endif

[rtl/slab_pkg.sv]
// Types and constants of the slab allocator: transaction structs, status
// codes, class sizes and the controller/datapath interface. No dependencies.
package slab_pkg;

   localparam int MAX_CLASSES = 8;
   localparam int CALC_W      = 12;

   // Operation codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Result status codes
   localparam logic [2:0] STAT_OK           = 3'd0;
   localparam logic [2:0] STAT_ZERO_SIZE    = 3'd1;
   localparam logic [2:0] STAT_TOO_LARGE    = 3'd2;
   localparam logic [2:0] STAT_EXHAUSTED    = 3'd3;
   localparam logic [2:0] STAT_FREE_IGNORED = 3'd4;

   // Entry size of each class
   localparam logic [CALC_W-1:0] CLASS_BYTES [MAX_CLASSES] = '{
      12'd16, 12'd32, 12'd64, 12'd128, 12'd256, 12'd512, 12'd1024, 12'd2048
   };

   typedef struct packed {
      logic        func;
      logic [15:0] request_size;
      logic        handle_valid;
      logic [8:0]  handle;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [8:0]  out_handle;
      logic [2:0]  size_class;
      logic [11:0] block_bytes;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_en;
      logic accept;
      logic pop;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic need_pop;
   } dp_stat_type;

endpackage

[rtl/slab_ctrl.sv]
// Controller of the slab allocator: link-memory clearing pass, accept and
// pop sequencing, result valid. Depends on slab_pkg.
module slab_ctrl import slab_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_stat_type dp_stat,
   output ctl_cmd_type cmd
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_POP   = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   // Take a transaction only when idle and the result register can take one
   assign req_stall = (state_ff != S_IDLE) | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (dp_stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept && dp_stat.need_pop) state_in = S_POP;
         end
         S_POP: begin
            state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // Result valid: set on accept, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign cmd.clear_en = (state_ff == S_CLEAR);
   assign cmd.accept   = accept;
   assign cmd.pop      = (state_ff == S_POP);

endmodule

[rtl/slab_dpath.sv]
// Datapath of the slab allocator: class decode, free-list heads, link
// memory with clearing counter, result register. Depends on slab_pkg.
module slab_dpath import slab_pkg::*; #(
   parameter int NUM_CLASSES = 8,
   parameter int SLOTS       = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  ctl_cmd_type cmd,
   output dp_stat_type dp_stat,
   output rsp_type     rsp_data
);

   localparam int SW    = $clog2(SLOTS);
   localparam int LW    = $clog2(SLOTS + 1);
   localparam int DEPTH = NUM_CLASSES * SLOTS;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [LW-1:0] NULL_LINK = LW'(SLOTS);

   // Free-list heads and link memory
   logic [LW-1:0] head_ff [MAX_CLASSES];
   logic [LW-1:0] link_mem [DEPTH];
   logic [LW-1:0] rd_data_ff;
   logic [2:0]    pop_cls_ff;
   rsp_type       rsp_data_ff, rsp_in;

   // Clearing counters
   logic [AW-1:0] clr_addr_ff;
   logic [SW-1:0] clr_slot_ff;
   logic [LW-1:0] clr_link;

   // Decode
   logic [3:0]        alloc_cnt;
   logic [2:0]        free_cls;
   logic              free_ok;
   logic              too_large;
   logic [2:0]        cls;
   logic [LW-1:0]     head_rd;
   logic              head_null;
   logic [CALC_W-1:0] handle_w;
   logic [CALC_W-1:0] base_w;
   logic [CALC_W-1:0] alloc_addr_w;
   logic [SW-1:0]     free_slot;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_addr;
   logic              free_wr;
   logic              need_pop;

   assign handle_w = {3'b000, req_data.handle};

   // Class of an allocate: number of classes too small for the request
   always_comb begin
      alloc_cnt = 4'd0;
      for (int k = 0; k < MAX_CLASSES; k++) begin
         if ({4'b0000, CLASS_BYTES[k]} < req_data.request_size) alloc_cnt = alloc_cnt + 4'd1;
      end
   end

   // Class of a free: number of class boundaries at or below the handle
   always_comb begin
      free_cls = 3'd0;
      for (int k = 1; k < MAX_CLASSES; k++) begin
         if (handle_w >= CALC_W'(k * SLOTS)) free_cls = free_cls + 3'd1;
      end
   end

   assign too_large    = (alloc_cnt >= 4'(NUM_CLASSES));
   assign free_ok      = req_data.handle_valid && (handle_w < CALC_W'(DEPTH));
   assign cls          = (req_data.func == FUNC_FREE) ? free_cls : alloc_cnt[2:0];
   assign head_rd      = head_ff[cls];
   assign head_null    = (head_rd == NULL_LINK);
   assign base_w       = CALC_W'(32'(cls) * SLOTS);
   assign alloc_addr_w = base_w + CALC_W'(head_rd);
   assign free_slot    = SW'(handle_w - base_w);
   assign rd_addr      = AW'(alloc_addr_w);
   assign wr_addr      = AW'(handle_w);
   assign free_wr      = (req_data.func == FUNC_FREE) && free_ok;
   assign need_pop     = (req_data.func == FUNC_ALLOC) && (req_data.request_size != 16'd0)
                         && !too_large && !head_null;

   // Result of the transaction
   always_comb begin
      rsp_in = '0;
      if (req_data.func == FUNC_ALLOC) begin
         if (req_data.request_size == 16'd0) begin
            rsp_in.status = STAT_ZERO_SIZE;
         end else if (too_large) begin
            rsp_in.status = STAT_TOO_LARGE;
         end else begin
            rsp_in.size_class  = cls;
            rsp_in.block_bytes = CLASS_BYTES[cls];
            if (head_null) begin
               rsp_in.status = STAT_EXHAUSTED;
            end else begin
               rsp_in.status     = STAT_OK;
               rsp_in.out_handle = alloc_addr_w[8:0];
            end
         end
      end else begin
         if (free_ok) begin
            rsp_in.status      = STAT_OK;
            rsp_in.size_class  = cls;
            rsp_in.block_bytes = CLASS_BYTES[cls];
         end else begin
            rsp_in.status = STAT_FREE_IGNORED;
         end
      end
   end

   // Initial link of the entry being cleared
   assign clr_link = (clr_slot_ff == SW'(SLOTS - 1)) ? NULL_LINK : LW'(clr_slot_ff) + LW'(1);

   // Heads and clearing counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < MAX_CLASSES; c++) head_ff[c] <= '0;
         clr_addr_ff <= '0;
         clr_slot_ff <= '0;
      end else begin
         if (cmd.clear_en) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
            clr_slot_ff <= (clr_slot_ff == SW'(SLOTS - 1)) ? '0 : clr_slot_ff + SW'(1);
         end
         if (cmd.accept && free_wr) head_ff[cls] <= LW'(free_slot);
         if (cmd.pop) head_ff[pop_cls_ff] <= rd_data_ff;
      end
   end

   // Link memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clear_en) link_mem[clr_addr_ff] <= clr_link;
      else if (cmd.accept && free_wr) link_mem[wr_addr] <= head_rd;
      if (cmd.accept) rd_data_ff <= link_mem[rd_addr];
   end

   // Result register and class of a pending pop
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rsp_data_ff <= rsp_in;
         pop_cls_ff  <= cls;
      end
   end

   assign dp_stat.clear_last = (clr_addr_ff == AW'(DEPTH - 1));
   assign dp_stat.need_pop   = need_pop;
   assign rsp_data           = rsp_data_ff;

endmodule

[rtl/slab_size_class_allocator_unit.sv]
// Slab allocator with power-of-two size classes (16 to 2048 bytes).
// Request channel: req_valid/req_stall/req_data carries one allocate or free
// transaction; result channel: rsp_valid/rsp_stall/rsp_data returns exactly
// one result per request, in order.
// The result is valid in the cycle after the request is accepted.
// A successful allocate is followed by the pop state (head read, then the
// registered link-memory read writes the new head back), in which req_stall
// is high; every other transaction leaves the controller idle.
// Reset: class heads go to slot zero and a clearing pass relinks all
// NUM_CLASSES*SLOTS link-memory entries (512 by default), one entry per
// cycle; req_stall stays high until it finishes.
// A stalled result holds in the output register; one new request is still
// taken as long as the previous result is taken in that same cycle.
// Handles are class*SLOTS + slot. Double frees are not detected.
// Depends on slab_pkg, slab_ctrl, slab_dpath and assert_macros.svh.
`include "assert_macros.svh"
module slab_size_class_allocator_unit import slab_pkg::*; #(
   parameter int NUM_CLASSES = 8,
   parameter int SLOTS       = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctl_cmd_type cmd;
   dp_stat_type dp_stat;

   slab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_stat   (dp_stat),
      .cmd       (cmd)
   );

   slab_dpath #(
      .NUM_CLASSES (NUM_CLASSES),
      .SLOTS       (SLOTS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .dp_stat  (dp_stat),
      .rsp_data (rsp_data)
   );

   // Every accepted transaction has its result presented next cycle
   `AST_NEXT(a_rsp_after_accept, req_valid && !req_stall, rsp_valid)
   // A head write-back only follows an accepted allocate
   `AST_IMPLY(a_pop_after_accept, cmd.pop, $past(cmd.accept))
   // No transaction is taken during the clearing pass
   `AST_IMPLY(a_stall_while_clear, cmd.clear_en, req_stall && !cmd.accept)

endmodule
